### sv/owtr_pkg.sv
// Shared types, codes and constants for the one-wire temperature reader.
package owtr_pkg;

    // Stream and configuration widths
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RESET_LOW       = 3'd0,
        REG_PRESENCE_SAMPLE = 3'd1,
        REG_PRESENCE_END    = 3'd2,
        REG_SLOT_HOLD       = 3'd3,
        REG_READ_TAIL       = 3'd4,
        REG_POLL_INTERVAL   = 3'd5,
        REG_POLL_LIMIT      = 3'd6
    } cfg_index_t;

    // Input item kinds (tuser)
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Completion status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_TIMEOUT     = 2'd2,
        ST_CRC_ERROR   = 2'd3
    } status_t;

    // Register reset values
    localparam logic [9:0]  RESET_LOW_DEFAULT       = 10'd480;
    localparam logic [7:0]  PRESENCE_SAMPLE_DEFAULT = 8'd64;
    localparam logic [9:0]  PRESENCE_END_DEFAULT    = 10'd300;
    localparam logic [6:0]  SLOT_HOLD_DEFAULT       = 7'd60;
    localparam logic [6:0]  READ_TAIL_DEFAULT       = 7'd50;
    localparam logic [15:0] POLL_INTERVAL_DEFAULT   = 16'd10000;
    localparam logic [7:0]  POLL_LIMIT_DEFAULT      = 8'd80;

    // Bus command bytes
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Fixed slot timings in ticks
    localparam logic [15:0] SLOT_LOW_TICKS = 16'd2;
    localparam logic [15:0] TAIL_EXTRA     = 16'd2;

    // Command byte sent at each position of the sequence
    function automatic logic [7:0] cmd_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SCRPD;
        endcase
        return b;
    endfunction

    // One byte through the CRC-8, LSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/one_wire_temperature_reader.sv
// One-wire bus master that sequences a full temperature read, one tick per item.
//
// Every input item is either a one microsecond tick (tuser 0, tdata[0] the sampled
// bus level) or a start command (tuser 1). Each accepted item produces exactly one
// result item in the next cycle, and a new item is accepted every cycle while the
// result register is free or being taken: the sequencer state is updated in a
// single registered step per item. A read runs reset/presence, skip-ROM, convert,
// conversion polling, a second reset, skip-ROM, read-scratchpad and nine read
// bytes with a CRC-8 check. The result tells whether the bus is driven low for the
// next microsecond, busy, status and the last good temperature in signed
// sixteenths of a degree; tlast marks the item on which a sequence ends.
// Configuration writes are taken at any time (cfg_ready is always high) and are
// used when a delay is next loaded.
module one_wire_temperature_reader (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [owtr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] line_level, [7:1] zero
    input  logic                                s_tuser,   // [0] cmd
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [owtr_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] drive_low, [1] busy_res,
                                                           // [3:2] status, [19:4] temperature,
                                                           // [23:20] zero
    output logic                                m_tlast,   // done_res
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owtr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import owtr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_PRES_SAMPLE,
        PH_PRES_END,
        PH_WR_LOW,
        PH_WR_HOLD,
        PH_WR_REC,
        PH_POLL_FIRST,
        PH_POLL_WAIT,
        PH_RD_LOW,
        PH_RD_SAMPLE,
        PH_RD_TAIL
    } phase_t;

    // Configuration registers
    logic [9:0]  reset_low_reg;
    logic [7:0]  presence_sample_reg;
    logic [9:0]  presence_end_reg;
    logic [6:0]  slot_hold_reg;
    logic [6:0]  read_tail_reg;
    logic [15:0] poll_interval_reg;
    logic [7:0]  poll_limit_reg;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  byte_reg, byte_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  poll_reg, poll_next;
    logic [15:0] raw_reg, raw_next;
    status_t     status_reg, status_next;
    logic [15:0] good_reg, good_next;

    // Result register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    logic       accept;
    logic       cmd;
    logic       line;
    logic       fin;
    logic       drive;
    logic [2:0] bit_inc;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = s_tuser;
    assign line      = s_tdata[0];
    assign bit_inc   = bit_reg + 3'd1;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Sequencer step for one item
    always_comb begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        crc_next    = crc_reg;
        poll_next   = poll_reg;
        raw_next    = raw_reg;
        status_next = status_reg;
        good_next   = good_reg;
        fin         = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (cmd == CMD_START) begin
                bit_next   = 3'd0;
                shift_next = 8'd0;
                crc_next   = 8'd0;
                poll_next  = 8'd0;
                byte_next  = 4'd0;
                phase_next = PH_RST_LOW;
                timer_next = {6'd0, reset_low_reg};
            end
        end else if (cmd == CMD_TICK) begin
            if (timer_reg > 16'd1) begin
                timer_next = timer_reg - 16'd1;
            end else begin
                timer_next = 16'd0;
                unique case (phase_reg)
                    PH_RST_LOW: begin
                        phase_next = PH_PRES_SAMPLE;
                        timer_next = {8'd0, presence_sample_reg};
                    end
                    PH_PRES_SAMPLE: begin
                        if (!line) begin
                            phase_next = PH_PRES_END;
                            timer_next = {6'd0, presence_end_reg};
                        end else if (byte_reg == 4'd0) begin
                            status_next = ST_NO_PRESENCE;
                            phase_next  = PH_IDLE;
                            fin         = 1'b1;
                        end else begin
                            shift_next = cmd_byte(byte_reg[1:0]);
                            bit_next   = 3'd0;
                            phase_next = PH_WR_LOW;
                            timer_next = SLOT_LOW_TICKS;
                        end
                    end
                    PH_PRES_END: begin
                        if (line || byte_reg != 4'd0) begin
                            shift_next = cmd_byte(byte_reg[1:0]);
                            bit_next   = 3'd0;
                            phase_next = PH_WR_LOW;
                            timer_next = SLOT_LOW_TICKS;
                        end else begin
                            status_next = ST_NO_PRESENCE;
                            phase_next  = PH_IDLE;
                            fin         = 1'b1;
                        end
                    end
                    PH_WR_LOW: begin
                        phase_next = PH_WR_HOLD;
                        timer_next = {9'd0, slot_hold_reg};
                    end
                    PH_WR_HOLD: begin
                        phase_next = PH_WR_REC;
                        timer_next = SLOT_LOW_TICKS;
                    end
                    PH_WR_REC: begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        bit_next   = bit_inc;
                        if (bit_inc != 3'd0) begin
                            phase_next = PH_WR_LOW;
                            timer_next = SLOT_LOW_TICKS;
                        end else if (byte_reg == 4'd1) begin
                            // convert sent: start polling at once
                            poll_next  = 8'd0;
                            phase_next = PH_POLL_FIRST;
                        end else if (byte_reg >= 4'd3) begin
                            // read-scratchpad sent: start reading
                            byte_next  = 4'd0;
                            bit_next   = 3'd0;
                            crc_next   = 8'd0;
                            phase_next = PH_RD_LOW;
                            timer_next = SLOT_LOW_TICKS;
                        end else begin
                            byte_next  = byte_reg + 4'd1;
                            shift_next = cmd_byte(byte_reg[1:0] + 2'd1);
                            bit_next   = 3'd0;
                            phase_next = PH_WR_LOW;
                            timer_next = SLOT_LOW_TICKS;
                        end
                    end
                    PH_POLL_FIRST: begin
                        if (line) begin
                            byte_next  = 4'd2;
                            phase_next = PH_RST_LOW;
                            timer_next = {6'd0, reset_low_reg};
                        end else begin
                            phase_next = PH_POLL_WAIT;
                            timer_next = poll_interval_reg;
                        end
                    end
                    PH_POLL_WAIT: begin
                        if (poll_reg >= poll_limit_reg) begin
                            status_next = ST_TIMEOUT;
                            phase_next  = PH_IDLE;
                            fin         = 1'b1;
                        end else begin
                            poll_next = poll_reg + 8'd1;
                            if (line) begin
                                byte_next  = 4'd2;
                                phase_next = PH_RST_LOW;
                                timer_next = {6'd0, reset_low_reg};
                            end else begin
                                phase_next = PH_POLL_WAIT;
                                timer_next = poll_interval_reg;
                            end
                        end
                    end
                    PH_RD_LOW: begin
                        phase_next = PH_RD_SAMPLE;
                        timer_next = SLOT_LOW_TICKS;
                    end
                    PH_RD_SAMPLE: begin
                        shift_next = {line, shift_reg[7:1]};
                        phase_next = PH_RD_TAIL;
                        timer_next = {9'd0, read_tail_reg} + TAIL_EXTRA;
                    end
                    PH_RD_TAIL: begin
                        bit_next = bit_inc;
                        if (bit_inc != 3'd0) begin
                            phase_next = PH_RD_LOW;
                            timer_next = SLOT_LOW_TICKS;
                        end else begin
                            // byte complete
                            if (byte_reg < 4'd8) begin
                                crc_next = crc_byte(crc_reg, shift_reg);
                            end
                            if (byte_reg == 4'd0) begin
                                raw_next = {raw_reg[15:8], shift_reg};
                            end else if (byte_reg == 4'd1) begin
                                raw_next = {shift_reg, raw_reg[7:0]};
                            end
                            if (byte_reg >= 4'd8) begin
                                phase_next = PH_IDLE;
                                fin        = 1'b1;
                                if (shift_reg == crc_reg) begin
                                    good_next   = raw_reg;
                                    status_next = ST_OK;
                                end else begin
                                    status_next = ST_CRC_ERROR;
                                end
                            end else begin
                                byte_next  = byte_reg + 4'd1;
                                phase_next = PH_RD_LOW;
                                timer_next = SLOT_LOW_TICKS;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        // Bus drive for the next microsecond
        if (phase_next == PH_RST_LOW || phase_next == PH_WR_LOW || phase_next == PH_RD_LOW) begin
            drive = 1'b1;
        end else if (phase_next == PH_WR_HOLD) begin
            drive = !shift_next[0];
        end else begin
            drive = 1'b0;
        end
    end

    // State, configuration and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg       <= RESET_LOW_DEFAULT;
            presence_sample_reg <= PRESENCE_SAMPLE_DEFAULT;
            presence_end_reg    <= PRESENCE_END_DEFAULT;
            slot_hold_reg       <= SLOT_HOLD_DEFAULT;
            read_tail_reg       <= READ_TAIL_DEFAULT;
            poll_interval_reg   <= POLL_INTERVAL_DEFAULT;
            poll_limit_reg      <= POLL_LIMIT_DEFAULT;
            phase_reg           <= PH_IDLE;
            timer_reg           <= 16'd0;
            bit_reg             <= 3'd0;
            byte_reg            <= 4'd0;
            shift_reg           <= 8'd0;
            crc_reg             <= 8'd0;
            poll_reg            <= 8'd0;
            raw_reg             <= 16'd0;
            status_reg          <= ST_OK;
            good_reg            <= 16'd0;
            m_tvalid_reg        <= 1'b0;
            m_tdata_reg         <= '0;
            m_tlast_reg         <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_RESET_LOW:       reset_low_reg       <= cfg_data[9:0];
                    REG_PRESENCE_SAMPLE: presence_sample_reg <= cfg_data[7:0];
                    REG_PRESENCE_END:    presence_end_reg    <= cfg_data[9:0];
                    REG_SLOT_HOLD:       slot_hold_reg       <= cfg_data[6:0];
                    REG_READ_TAIL:       read_tail_reg       <= cfg_data[6:0];
                    REG_POLL_INTERVAL:   poll_interval_reg   <= cfg_data;
                    REG_POLL_LIMIT:      poll_limit_reg      <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg    <= phase_next;
                timer_reg    <= timer_next;
                bit_reg      <= bit_next;
                byte_reg     <= byte_next;
                shift_reg    <= shift_next;
                crc_reg      <= crc_next;
                poll_reg     <= poll_next;
                raw_reg      <= raw_next;
                status_reg   <= status_next;
                good_reg     <= good_next;
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {4'd0, good_next, status_next, (phase_next != PH_IDLE), drive};
                m_tlast_reg  <= fin;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/owtr_checker.sv
// Port-level assertions for the one-wire temperature reader, bound to the top level.
module owtr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [owtr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic                                m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // empty result register always takes an item
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // an accepted item gives a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // the finishing item is not busy and never drives the bus
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[1] && !m_tdata[0])
        else $error("finishing item busy or driving");

    // bus is only driven during a sequence
    a_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("bus driven while idle");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (.*);

### bench/one_wire_temperature_reader_tb.sv
// Self-checking stream testbench for the one-wire temperature reader, with a sensor model on the bus.
module one_wire_temperature_reader_tb;
    import owtr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 800;
    localparam int MAX_REPORTS   = 50;

    // Index past the last register; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [15:0] TWO_TICKS = 16'd2;

    // Sequencer steps of the expected-behavior model
    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_PRES_SAMPLE, SEQ_PRES_END,
        SEQ_WR_LOW, SEQ_WR_HOLD, SEQ_WR_REC, SEQ_POLL_FIRST,
        SEQ_POLL_WAIT, SEQ_RD_LOW, SEQ_RD_SAMPLE, SEQ_RD_TAIL
    } seq_phase_t;

    // One expected result item
    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        status_t     status;
        logic [15:0] temperature;
    } readout_t;

    // DUT ports
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // [0] line_level
    logic                   s_tuser   = CMD_TICK; // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [0] drive_low, [1] busy, [3:2] status,
                                                // [19:4] temperature
    logic                   m_tlast;            // done
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    one_wire_temperature_reader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Model copy of the timing registers
    logic [9:0]  cfg_reset_low;
    logic [7:0]  cfg_pres_sample;
    logic [9:0]  cfg_pres_end;
    logic [6:0]  cfg_slot_hold;
    logic [6:0]  cfg_read_tail;
    logic [15:0] cfg_poll_interval;
    logic [7:0]  cfg_poll_limit;

    // Model copy of the sequencer state
    seq_phase_t  cur_phase;
    logic [15:0] wait_cnt;
    logic [2:0]  bit_idx;
    logic [3:0]  byte_idx;
    logic [7:0]  shreg;
    logic [7:0]  crc_acc;
    logic [7:0]  polls;
    logic [15:0] raw_temp;
    status_t     last_st;
    logic [15:0] good_temp;
    logic        seq_done;

    readout_t pending_readouts[$];

    // Bookkeeping
    int mismatches      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int counted_items   = 0;
    int cfg_writes      = 0;
    int burst_left      = 1;
    int status_counts [4];

    // Sensor behavior for the current read
    logic       want_pres1, want_end1, want_pres2, want_end2;
    int         ready_after;
    int         noise_pm;
    logic       stray_starts;
    logic [7:0] scratch [0:8];

    // Reflected CRC-8, poly 0x8C, LSB first
    function automatic logic [7:0] crc8_reflected(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    task automatic reset_reader();
        cfg_reset_low     = RESET_LOW_DEFAULT;
        cfg_pres_sample   = PRESENCE_SAMPLE_DEFAULT;
        cfg_pres_end      = PRESENCE_END_DEFAULT;
        cfg_slot_hold     = SLOT_HOLD_DEFAULT;
        cfg_read_tail     = READ_TAIL_DEFAULT;
        cfg_poll_interval = POLL_INTERVAL_DEFAULT;
        cfg_poll_limit    = POLL_LIMIT_DEFAULT;
        cur_phase = SEQ_IDLE;
        wait_cnt  = '0;
        bit_idx   = '0;
        byte_idx  = '0;
        shreg     = '0;
        crc_acc   = '0;
        polls     = '0;
        raw_temp  = '0;
        last_st   = ST_OK;
        good_temp = '0;
        seq_done  = 1'b0;
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_RESET_LOW:       cfg_reset_low     = data[9:0];
            REG_PRESENCE_SAMPLE: cfg_pres_sample   = data[7:0];
            REG_PRESENCE_END:    cfg_pres_end      = data[9:0];
            REG_SLOT_HOLD:       cfg_slot_hold     = data[6:0];
            REG_READ_TAIL:       cfg_read_tail     = data[6:0];
            REG_POLL_INTERVAL:   cfg_poll_interval = data;
            REG_POLL_LIMIT:      cfg_poll_limit    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic load_phase(input seq_phase_t ph, input logic [15:0] t);
        cur_phase = ph;
        wait_cnt  = t;
    endtask

    task automatic end_sequence(input status_t st);
        last_st   = st;
        cur_phase = SEQ_IDLE;
        wait_cnt  = '0;
        seq_done  = 1'b1;
    endtask

    // Load the command byte for the current position and open its first slot
    task automatic begin_write_byte();
        case (byte_idx[1:0])
            2'd0, 2'd2: shreg = CMD_SKIP_ROM;
            2'd1:       shreg = CMD_CONVERT;
            default:    shreg = CMD_READ_SCRPD;
        endcase
        bit_idx = '0;
        load_phase(SEQ_WR_LOW, TWO_TICKS);
    endtask

    task automatic begin_bus_reset(input logic [3:0] which);
        byte_idx = which;
        load_phase(SEQ_RST_LOW, {6'd0, cfg_reset_low});
    endtask

    // A scratchpad byte is complete: CRC, temperature capture, final check
    task automatic finish_read_byte();
        logic [7:0] b;
        b = shreg;
        if (byte_idx < 4'd8) crc_acc = crc8_reflected(crc_acc, b);
        if (byte_idx == 4'd0) raw_temp[7:0] = b;
        else if (byte_idx == 4'd1) raw_temp[15:8] = b;
        if (byte_idx >= 4'd8) begin
            if (b == crc_acc) begin
                good_temp = raw_temp;
                end_sequence(ST_OK);
            end else begin
                end_sequence(ST_CRC_ERROR);
            end
        end else begin
            byte_idx = byte_idx + 4'd1;
            load_phase(SEQ_RD_LOW, TWO_TICKS);
        end
    endtask

    // Action taken on the last tick of a phase
    task automatic bus_action(input logic lv);
        case (cur_phase)
            SEQ_RST_LOW: load_phase(SEQ_PRES_SAMPLE, {8'd0, cfg_pres_sample});
            SEQ_PRES_SAMPLE: begin
                if (!lv) load_phase(SEQ_PRES_END, {6'd0, cfg_pres_end});
                else if (byte_idx == 4'd0) end_sequence(ST_NO_PRESENCE);
                else begin_write_byte();
            end
            SEQ_PRES_END: begin
                if (lv || byte_idx != 4'd0) begin_write_byte();
                else end_sequence(ST_NO_PRESENCE);
            end
            SEQ_WR_LOW:  load_phase(SEQ_WR_HOLD, {9'd0, cfg_slot_hold});
            SEQ_WR_HOLD: load_phase(SEQ_WR_REC, TWO_TICKS);
            SEQ_WR_REC: begin
                shreg   = {1'b0, shreg[7:1]};
                bit_idx = bit_idx + 3'd1;
                if (bit_idx != 3'd0) begin
                    load_phase(SEQ_WR_LOW, TWO_TICKS);
                end else if (byte_idx == 4'd1) begin
                    polls = '0;
                    load_phase(SEQ_POLL_FIRST, 16'd0);
                end else if (byte_idx >= 4'd3) begin
                    byte_idx = '0;
                    bit_idx  = '0;
                    crc_acc  = '0;
                    load_phase(SEQ_RD_LOW, TWO_TICKS);
                end else begin
                    byte_idx = byte_idx + 4'd1;
                    begin_write_byte();
                end
            end
            SEQ_POLL_FIRST: begin
                if (lv) begin_bus_reset(4'd2);
                else load_phase(SEQ_POLL_WAIT, cfg_poll_interval);
            end
            SEQ_POLL_WAIT: begin
                if (polls >= cfg_poll_limit) begin
                    end_sequence(ST_TIMEOUT);
                end else begin
                    polls = polls + 8'd1;
                    if (lv) begin_bus_reset(4'd2);
                    else load_phase(SEQ_POLL_WAIT, cfg_poll_interval);
                end
            end
            SEQ_RD_LOW: load_phase(SEQ_RD_SAMPLE, TWO_TICKS);
            SEQ_RD_SAMPLE: begin
                shreg = {lv, shreg[7:1]};
                load_phase(SEQ_RD_TAIL, {9'd0, cfg_read_tail} + TWO_TICKS);
            end
            SEQ_RD_TAIL: begin
                bit_idx = bit_idx + 3'd1;
                if (bit_idx != 3'd0) load_phase(SEQ_RD_LOW, TWO_TICKS);
                else finish_read_byte();
            end
            default: begin
                cur_phase = SEQ_IDLE;
                wait_cnt  = '0;
            end
        endcase
    endtask

    // Advance the model by one accepted input item and form its result
    task automatic predict_readout(input logic cmd, input logic lv, output readout_t r);
        seq_done = 1'b0;
        if (cur_phase == SEQ_IDLE) begin
            if (cmd == CMD_START) begin
                bit_idx = '0;
                shreg   = '0;
                crc_acc = '0;
                polls   = '0;
                begin_bus_reset(4'd0);
            end
        end else if (cmd == CMD_TICK) begin
            if (wait_cnt > 16'd1) begin
                wait_cnt = wait_cnt - 16'd1;
            end else begin
                wait_cnt = '0;
                bus_action(lv);
            end
        end
        r.drive_low = (cur_phase == SEQ_RST_LOW || cur_phase == SEQ_WR_LOW ||
                       cur_phase == SEQ_RD_LOW) ? 1'b1 :
                      (cur_phase == SEQ_WR_HOLD) ? ~shreg[0] : 1'b0;
        r.busy        = (cur_phase != SEQ_IDLE);
        r.done        = seq_done;
        r.status      = last_st;
        r.temperature = good_temp;
    endtask

    // Bus level the sensor presents for the next tick, from the model's current step
    function automatic logic sensor_line();
        logic lv;
        case (cur_phase)
            SEQ_PRES_SAMPLE: lv = (byte_idx == 4'd0) ? ~want_pres1 : ~want_pres2;
            SEQ_PRES_END:    lv = (byte_idx == 4'd0) ? want_end1 : want_end2;
            SEQ_POLL_FIRST:  lv = (ready_after == 0);
            SEQ_POLL_WAIT:   lv = (int'(polls) + 1 >= ready_after);
            SEQ_RD_SAMPLE:   lv = scratch[byte_idx][bit_idx];
            default:         lv = 1'($urandom_range(0, 1));
        endcase
        if (noise_pm != 0 && $urandom_range(0, 999) < noise_pm) lv = ~lv;
        return lv;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR result %0d: %s got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    // Send one item; the sender works in bursts with idle gaps between them
    task automatic send_item(input logic cmd, input logic lv);
        readout_t r;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, lv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_readout(cmd, lv, r);
        pending_readouts.push_back(r);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 400)
                                                      : $urandom_range(1, 32);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and wait for every expected result
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_readouts.size() != 0) begin
            report_mismatch("results never delivered", pending_readouts.size(), 0);
            pending_readouts.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_setting(input logic [15:0] rl, input logic [15:0] ps,
                                 input logic [15:0] pe, input logic [15:0] sh,
                                 input logic [15:0] rt, input logic [15:0] pi,
                                 input logic [15:0] pl);
        write_reg(REG_RESET_LOW, rl);
        write_reg(REG_PRESENCE_SAMPLE, ps);
        write_reg(REG_PRESENCE_END, pe);
        write_reg(REG_SLOT_HOLD, sh);
        write_reg(REG_READ_TAIL, rt);
        write_reg(REG_POLL_INTERVAL, pi);
        write_reg(REG_POLL_LIMIT, pl);
    endtask

    // Well-behaved sensor with a given reading
    task automatic clean_scenario(input logic [15:0] temp, input logic crc_ok, input int ready);
        logic [7:0] crc;
        want_pres1   = 1'b1;
        want_end1    = 1'b1;
        want_pres2   = 1'b1;
        want_end2    = 1'b1;
        ready_after  = ready;
        noise_pm     = 0;
        stray_starts = 1'b0;
        scratch[0]   = temp[7:0];
        scratch[1]   = temp[15:8];
        crc = crc8_reflected(8'd0, scratch[0]);
        crc = crc8_reflected(crc, scratch[1]);
        for (int i = 2; i < 8; i++) begin
            scratch[i] = 8'($urandom_range(0, 255));
            crc = crc8_reflected(crc, scratch[i]);
        end
        scratch[8] = crc_ok ? crc : crc ^ 8'($urandom_range(1, 255));
    endtask

    // Mostly well-formed reads with random content; some faults and bus noise
    task automatic random_scenario();
        logic [15:0] temp;
        int ready;
        case ($urandom_range(0, 7))
            0:       temp = 16'h8000;
            1:       temp = 16'h7FFF;
            2:       temp = 16'hFFFF;
            3:       temp = 16'h0000;
            default: temp = 16'($urandom_range(0, 16'hFFFF));
        endcase
        ready = ($urandom_range(0, 3) == 0) ? int'(cfg_poll_limit) + 1
                                            : $urandom_range(0, cfg_poll_limit);
        clean_scenario(temp, $urandom_range(0, 4) != 0, ready);
        want_pres1   = ($urandom_range(0, 9) != 0);
        want_end1    = ($urandom_range(0, 9) != 0);
        want_pres2   = ($urandom_range(0, 4) != 0);
        want_end2    = ($urandom_range(0, 4) != 0);
        noise_pm     = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 20) : 0;
        stray_starts = ($urandom_range(0, 2) == 0);
    endtask

    // One read from start to the end of the sequence, then a few idle ticks
    task automatic run_read();
        send_item(CMD_START, 1'($urandom_range(0, 1)));
        counted_items++;
        while (cur_phase != SEQ_IDLE) begin
            if (stray_starts && $urandom_range(0, 63) == 0) begin
                // ignored while busy
                send_item(CMD_START, 1'($urandom_range(0, 1)));
            end else begin
                send_item(CMD_TICK, sensor_line());
                counted_items++;
            end
        end
        repeat ($urandom_range(0, 2)) send_item(CMD_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Idle ticks, start while busy, missing presence and a line stuck low
    task automatic test_idle_and_presence();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_START, 1'b1);
        send_item(CMD_START, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_START, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        drain_results();
    endtask

    // Second presence faults, bad CRC and both ends of the poll limit
    task automatic test_fault_paths();
        write_setting(16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd3);
        clean_scenario(16'h0191, 1'b0, 2);
        want_pres2 = 1'b0;
        run_read();
        clean_scenario(16'hFE6F, 1'b1, 0);
        want_end2 = 1'b0;
        run_read();
        drain_results();
        write_reg(REG_POLL_LIMIT, 16'd0);
        clean_scenario(16'h0550, 1'b1, 1);
        run_read();
        drain_results();
        write_reg(REG_POLL_LIMIT, 16'd255);
        clean_scenario(16'h0550, 1'b1, 256);
        run_read();
        drain_results();
    endtask

    // Random reads over a series of short timing settings
    task automatic test_random_reads();
        int start_count;
        start_count = counted_items;
        while (counted_items - start_count < RANDOM_ITEMS) begin
            write_setting(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 4)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
            repeat ($urandom_range(1, 3)) begin
                random_scenario();
                run_read();
            end
            drain_results();
        end
    endtask

    // All registers written with all ones, masked to their widths; no sensor answers
    task automatic test_max_timings();
        write_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        clean_scenario(16'h07D0, 1'b1, 0);
        want_pres1 = 1'b0;
        run_read();
        drain_results();
    endtask

    // Power-up timing values restored; line still low at the presence end check
    task automatic test_default_timings();
        write_setting(16'(RESET_LOW_DEFAULT), 16'(PRESENCE_SAMPLE_DEFAULT),
                      16'(PRESENCE_END_DEFAULT), 16'(SLOT_HOLD_DEFAULT),
                      16'(READ_TAIL_DEFAULT), POLL_INTERVAL_DEFAULT,
                      16'(POLL_LIMIT_DEFAULT));
        clean_scenario(16'hFC90, 1'b1, 0);
        want_end1 = 1'b0;
        run_read();
        drain_results();
    endtask

    // Receiver: full speed, random, bursty stalls or a fixed pattern, switching over time
    logic [31:0] rx_cycle   = '0;
    int          stall_left = 0;
    always @(posedge aclk) begin
        rx_cycle++;
        case (rx_cycle[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 16);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
            default: m_tready <= (rx_cycle[1:0] != 2'd0);
        endcase
    end

    // Compare every delivered result with the oldest expectation
    always @(posedge aclk) begin
        readout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readouts.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(m_tdata), 0);
            end else begin
                want = pending_readouts.pop_front();
                if (m_tdata[0] !== want.drive_low)
                    report_mismatch("drive_low", 32'(m_tdata[0]), 32'(want.drive_low));
                if (m_tdata[1] !== want.busy)
                    report_mismatch("busy", 32'(m_tdata[1]), 32'(want.busy));
                if (m_tlast !== want.done)
                    report_mismatch("done", 32'(m_tlast), 32'(want.done));
                if (m_tdata[3:2] !== want.status)
                    report_mismatch("status", 32'(m_tdata[3:2]), 32'(want.status));
                if (m_tdata[19:4] !== want.temperature)
                    report_mismatch("temperature", 32'(m_tdata[19:4]),
                                    32'(want.temperature));
                if (want.done) status_counts[want.status]++;
            end
            results_checked++;
        end
    end

    // Timeout
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("one_wire_temperature_reader: mismatch");
            $finish;
        end
    end

    // Test sequence
    initial begin
        for (int i = 0; i < 4; i++) status_counts[i] = 0;
        reset_reader();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_and_presence();
        test_fault_paths();
        test_random_reads();
        test_max_timings();
        test_default_timings();
        drain_results();
        $display("Sent %0d items over %0d register writes; %0d results checked, %0d mismatches",
                 items_sent, cfg_writes, results_checked, mismatches);
        $display("Reads ended: %0d ok, %0d no presence, %0d poll timeout, %0d bad CRC",
                 status_counts[ST_OK], status_counts[ST_NO_PRESENCE],
                 status_counts[ST_TIMEOUT], status_counts[ST_CRC_ERROR]);
        if (mismatches == 0) begin
            $display("one_wire_temperature_reader: match");
        end else begin
            $display("one_wire_temperature_reader: mismatch");
        end
        $finish;
    end

endmodule
